[sv/rom_read_patcher_three_slot_assert.svh]
`ifndef ROM_READ_PATCHER_THREE_SLOT_ASSERT_SVH
`define ROM_READ_PATCHER_THREE_SLOT_ASSERT_SVH

// checked only out of reset
`define RRPTS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rrpts check failed");

// checked on every edge, reset included
`define RRPTS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("rrpts check failed");

`endif

[sv/rrpts_pkg.sv]
package rrpts_pkg;

    localparam int ADDR_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int HIT_W   = 2;
    localparam int N_SLOTS = 3;
    localparam int SLOT_W  = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [ADDR_W-1:0] C_CTRL_ADDR  = 16'h8000;
    localparam logic [ADDR_W-1:0] C_SLOT_FIRST = 16'h8001;
    localparam logic [ADDR_W-1:0] C_SLOT_LAST  = 16'h800C;

    localparam logic [BYTE_W-1:0] C_CTRL_RESET = 8'h80;
    localparam logic [BYTE_W-1:0] C_CTRL_MASK  = 8'h7E;
    localparam logic [BYTE_W-1:0] C_END_SETUP  = 8'h7F;

    localparam int SETUP_BIT = 7;
    localparam int CMP_LSB   = 1;
    localparam int DIS_LSB   = 4;

    typedef enum logic [1:0] {
        F_ADDR_HI = 2'd0,
        F_ADDR_LO = 2'd1,
        F_CMP     = 2'd2,
        F_REP     = 2'd3
    } t_field;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] bus_address;
        logic [BYTE_W-1:0] bus_byte;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [HIT_W-1:0]  hit_slot;
        logic              patching_on;
    } t_rsp;

endpackage

[sv/rrpts_in_if.sv]
interface rrpts_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [rrpts_pkg::ADDR_W-1:0] bus_address;
    logic [rrpts_pkg::BYTE_W-1:0] bus_byte;

    modport source (output valid, command, bus_address, bus_byte, input ready);
    modport sink   (input valid, command, bus_address, bus_byte, output ready);
endinterface

[sv/rrpts_out_if.sv]
interface rrpts_out_if;
    logic                         valid;
    logic                         ready;
    logic [rrpts_pkg::BYTE_W-1:0] read_byte;
    logic [rrpts_pkg::HIT_W-1:0]  hit_slot;
    logic                         patching_on;

    modport source (output valid, read_byte, hit_slot, patching_on, input ready);
    modport sink   (input valid, read_byte, hit_slot, patching_on, output ready);
endinterface

[sv/rrpts_in_stage.sv]
module rrpts_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rrpts_in_if.sink          i_in,
    input  logic              i_can_load,
    output rrpts_pkg::t_req   o_req,
    output logic              o_fire
);
    import rrpts_pkg::*;

    logic r_valid;
    logic n_valid;
    t_req r_req;

    assign i_in.ready = !r_valid || i_can_load;
    assign o_fire     = r_valid && i_can_load;
    assign o_req      = r_req;

    always_comb begin
        n_valid = r_valid;
        if (i_in.ready) begin
            n_valid = i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req.command     <= i_in.command;
            r_req.bus_address <= i_in.bus_address;
            r_req.bus_byte    <= i_in.bus_byte;
        end
    end

endmodule

[sv/rrpts_core.sv]
`include "rom_read_patcher_three_slot_assert.svh"

module rrpts_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rrpts_pkg::t_req i_req,
    input  logic            i_fire,
    output rrpts_pkg::t_rsp o_rsp
);
    import rrpts_pkg::*;

    logic [BYTE_W-1:0] r_ctrl;
    logic [BYTE_W-1:0] n_ctrl;
    logic [ADDR_W-1:0] r_addr [N_SLOTS];
    logic [ADDR_W-1:0] n_addr [N_SLOTS];
    logic [BYTE_W-1:0] r_cmp  [N_SLOTS];
    logic [BYTE_W-1:0] n_cmp  [N_SLOTS];
    logic [BYTE_W-1:0] r_rep  [N_SLOTS];
    logic [BYTE_W-1:0] n_rep  [N_SLOTS];
    logic [3:0]        off;
    logic [SLOT_W-1:0] sel;
    logic              in_slots;
    logic              setup;

    assign setup    = r_ctrl[SETUP_BIT];
    assign off      = 4'(i_req.bus_address[3:0] - 4'd1);
    assign sel      = off[3:2];
    assign in_slots = (i_req.bus_address >= C_SLOT_FIRST) &&
                      (i_req.bus_address <= C_SLOT_LAST);

    // setup writes
    always_comb begin
        n_ctrl = r_ctrl;
        n_addr = r_addr;
        n_cmp  = r_cmp;
        n_rep  = r_rep;
        if (i_req.command == CMD_WRITE && setup) begin
            if (i_req.bus_address == C_CTRL_ADDR) begin
                if (i_req.bus_byte[0]) begin
                    n_ctrl = C_CTRL_RESET | (i_req.bus_byte & C_CTRL_MASK);
                end else begin
                    n_ctrl = r_ctrl & C_END_SETUP;
                end
            end else if (in_slots) begin
                case (t_field'(off[1:0]))
                    F_ADDR_HI: n_addr[sel][15:8] = i_req.bus_byte;
                    F_ADDR_LO: n_addr[sel][7:0]  = i_req.bus_byte;
                    F_CMP:     n_cmp[sel]        = i_req.bus_byte;
                    F_REP:     n_rep[sel]        = i_req.bus_byte;
                    default:   n_cmp[sel]        = r_cmp[sel];
                endcase
            end
        end
    end

    // read match, slot 0 wins
    always_comb begin
        o_rsp.read_byte   = '0;
        o_rsp.hit_slot    = '0;
        o_rsp.patching_on = !n_ctrl[SETUP_BIT];
        if (i_req.command == CMD_READ) begin
            o_rsp.read_byte = i_req.bus_byte;
            if (!setup && i_req.bus_address >= C_CTRL_ADDR) begin
                for (int i = N_SLOTS - 1; i >= 0; i--) begin
                    if (!r_ctrl[DIS_LSB + i] && i_req.bus_address == r_addr[i] &&
                        (!r_ctrl[CMP_LSB + i] || i_req.bus_byte == r_cmp[i])) begin
                        o_rsp.read_byte = r_rep[i];
                        o_rsp.hit_slot  = HIT_W'(i + 1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= C_CTRL_RESET;
            for (int i = 0; i < N_SLOTS; i++) begin
                r_addr[i] <= '0;
                r_cmp[i]  <= '0;
                r_rep[i]  <= '0;
            end
        end else if (i_fire) begin
            r_ctrl <= n_ctrl;
            r_addr <= n_addr;
            r_cmp  <= n_cmp;
            r_rep  <= n_rep;
        end
    end

    `RRPTS_ASSERT(a_setup_never_returns, !r_ctrl[SETUP_BIT] |=> !r_ctrl[SETUP_BIT])
    `RRPTS_ASSERT(a_hit_only_patched_read, (o_rsp.hit_slot != '0) |-> (i_req.command == CMD_READ && !setup))
    `RRPTS_ASSERT(a_write_gives_zero, (i_req.command == CMD_WRITE) |-> (o_rsp.read_byte == '0 && o_rsp.hit_slot == '0))

endmodule

[sv/rrpts_out_stage.sv]
`include "rom_read_patcher_three_slot_assert.svh"

module rrpts_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rrpts_pkg::t_rsp i_rsp,
    input  logic            i_fire,
    output logic            o_can_load,
    rrpts_out_if.source     o_out
);
    import rrpts_pkg::*;

    logic r_valid;
    logic n_valid;
    t_rsp r_rsp;

    assign o_can_load        = !r_valid || o_out.ready;
    assign o_out.valid       = r_valid;
    assign o_out.read_byte   = r_rsp.read_byte;
    assign o_out.hit_slot    = r_rsp.hit_slot;
    assign o_out.patching_on = r_rsp.patching_on;

    always_comb begin
        n_valid = r_valid;
        if (o_can_load) begin
            n_valid = i_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_rsp <= i_rsp;
        end
    end

    `RRPTS_ASSERT_ALWAYS(a_empty_after_reset, $past(!i_rst_n) |-> !r_valid)

endmodule

[sv/rom_read_patcher_three_slot.sv]
// a result is registered in the input register, then in the result register, before it is valid
// throughput: one bus access per cycle, full rate under no output stall
// a waiting result does not block the next input transfer while the input stage is free
// reset (i_rst_n low, synchronous): setup mode, control 0x80, all slots zero, no result pending
module rom_read_patcher_three_slot (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rrpts_in_if.sink     i_in,
    rrpts_out_if.source  o_out
);
    import rrpts_pkg::*;

    t_req req;
    t_rsp rsp;
    logic fire;
    logic can_load;

    rrpts_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_can_load (can_load),
        .o_req      (req),
        .o_fire     (fire)
    );

    rrpts_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_fire  (fire),
        .o_rsp   (rsp)
    );

    rrpts_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rsp      (rsp),
        .i_fire     (fire),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

[bench/tb_top.sv]
module tb_top;
    import rrpts_pkg::*;

    typedef struct packed {
        bit   hold;
        t_req req;
    } t_bus_item;

    logic clk = 1'b0;
    logic rst_n;

    rrpts_in_if  in_if ();
    rrpts_out_if out_if ();

    rom_read_patcher_three_slot u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // bus accesses waiting to be driven and results still owed by the block
    t_bus_item pending_access_q[$];
    t_rsp      predicted_rsp_q[$];
    t_bus_item cur_access;

    // predictor copy of the patch state
    logic [BYTE_W-1:0] ctrl_q;
    logic [ADDR_W-1:0] slot_addr_q [N_SLOTS];
    logic [BYTE_W-1:0] slot_cmp_q [N_SLOTS];
    logic [BYTE_W-1:0] slot_rep_q [N_SLOTS];

    int unsigned n_loaded;
    int unsigned idle_phase;
    int unsigned n_reads;
    int unsigned n_writes;
    int unsigned n_results;
    int unsigned fail_count;
    int unsigned slot_hits [4];

    function automatic t_rsp patch_bus_access(t_req req);
        t_rsp          rsp;
        logic [ADDR_W-1:0] off;
        int            n;
        bit            found;
        rsp   = '0;
        found = 1'b0;
        if (req.command == CMD_WRITE) begin
            if (ctrl_q[SETUP_BIT]) begin
                if (req.bus_address == C_CTRL_ADDR) begin
                    if (req.bus_byte[0]) begin
                        ctrl_q = C_CTRL_RESET | (req.bus_byte & C_CTRL_MASK);
                    end else begin
                        ctrl_q[SETUP_BIT] = 1'b0;
                    end
                end else if (req.bus_address >= C_SLOT_FIRST &&
                             req.bus_address <= C_SLOT_LAST) begin
                    off = req.bus_address - C_SLOT_FIRST;
                    n   = int'(off[3:2]);
                    case (t_field'(off[1:0]))
                        F_ADDR_HI: slot_addr_q[n][15:8] = req.bus_byte;
                        F_ADDR_LO: slot_addr_q[n][7:0]  = req.bus_byte;
                        F_CMP:     slot_cmp_q[n]        = req.bus_byte;
                        F_REP:     slot_rep_q[n]        = req.bus_byte;
                        default:   ;
                    endcase
                end
            end
        end else begin
            rsp.read_byte = req.bus_byte;
            if (!ctrl_q[SETUP_BIT] && req.bus_address >= C_CTRL_ADDR) begin
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (!found && !ctrl_q[DIS_LSB + i] &&
                        slot_addr_q[i] == req.bus_address &&
                        (!ctrl_q[CMP_LSB + i] || slot_cmp_q[i] == req.bus_byte)) begin
                        found         = 1'b1;
                        rsp.read_byte = slot_rep_q[i];
                        rsp.hit_slot  = HIT_W'(i + 1);
                    end
                end
            end
        end
        rsp.patching_on = !ctrl_q[SETUP_BIT];
        return rsp;
    endfunction

    function automatic int unsigned sender_idle_pct(int unsigned ph);
        case (ph)
            1:       return 48;
            3:       return 13;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct(int unsigned ph);
        case (ph)
            2:       return 48;
            3:       return 13;
            default: return 0;
        endcase
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid       <= 1'b0;
            in_if.command     <= CMD_WRITE;
            in_if.bus_address <= '0;
            in_if.bus_byte    <= '0;
            ctrl_q            = C_CTRL_RESET;
            for (int i = 0; i < N_SLOTS; i++) begin
                slot_addr_q[i] = '0;
                slot_cmp_q[i]  = '0;
                slot_rep_q[i]  = '0;
            end
        end else begin
            if (in_if.valid && in_if.ready) begin
                predicted_rsp_q.push_back(patch_bus_access(cur_access.req));
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_access_q.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct(idle_phase) &&
                    !(pending_access_q[0].hold && predicted_rsp_q.size() > 0)) begin
                    cur_access        = pending_access_q.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.command     <= cur_access.req.command;
                    in_if.bus_address <= cur_access.req.bus_address;
                    in_if.bus_byte    <= cur_access.req.bus_byte;
                    n_loaded++;
                    idle_phase        <= (n_loaded / 64) % 4;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_rsp want;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_results++;
                if (predicted_rsp_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected transfer: read_byte %02h hit_slot %0d patching_on %0b",
                                 out_if.read_byte, out_if.hit_slot, out_if.patching_on);
                    end
                end else begin
                    want = predicted_rsp_q.pop_front();
                    slot_hits[want.hit_slot]++;
                    if (out_if.read_byte !== want.read_byte ||
                        out_if.hit_slot !== want.hit_slot ||
                        out_if.patching_on !== want.patching_on) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch at result %0d: exp %02h/%0d/%0b got %02h/%0d/%0b",
                                     n_results, want.read_byte, want.hit_slot,
                                     want.patching_on, out_if.read_byte,
                                     out_if.hit_slot, out_if.patching_on);
                        end
                    end
                end
            end
            out_if.ready <= ($urandom_range(99) >= receiver_stall_pct(idle_phase));
        end
    end

    task automatic add_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] data, input bit hold);
        t_bus_item item;
        item.hold            = hold;
        item.req.command     = cmd;
        item.req.bus_address = addr;
        item.req.bus_byte    = data;
        pending_access_q.push_back(item);
        if (cmd == CMD_READ) begin
            n_reads++;
        end else begin
            n_writes++;
        end
    endtask

    initial begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0] plan_addr [N_SLOTS];
        logic [BYTE_W-1:0] plan_cmp [N_SLOTS];
        logic [BYTE_W-1:0] plan_rep [N_SLOTS];
        logic [BYTE_W-1:0] plan_ctrl;
        logic [BYTE_W-1:0] fld;
        int                n_counted;
        int                sel;
        int                k;
        int                start;
        bit                hold;

        in_if.valid       = 1'b0;
        in_if.command     = CMD_WRITE;
        in_if.bus_address = '0;
        in_if.bus_byte    = '0;
        out_if.ready      = 1'b0;
        n_loaded          = 0;
        idle_phase        = 0;
        n_reads           = 0;
        n_writes          = 0;
        n_results         = 0;
        fail_count        = 0;
        for (int i = 0; i < 4; i++) slot_hits[i] = 0;

        // patch setup that the whole run will use
        plan_addr[0] = ($urandom_range(3) == 0) ? 16'hFFFF : 16'(16'h8000 | $urandom);
        plan_addr[1] = $urandom_range(1) ? plan_addr[0] : 16'(16'h8000 | $urandom);
        sel = $urandom_range(3);
        if (sel == 0) begin
            plan_addr[2] = 16'($urandom) & 16'h7FFF;
        end else if (sel == 1) begin
            plan_addr[2] = plan_addr[1];
        end else begin
            plan_addr[2] = 16'(16'h8000 | $urandom);
        end
        plan_ctrl = 8'h01;
        for (int i = 0; i < N_SLOTS; i++) begin
            plan_cmp[i] = 8'($urandom);
            plan_rep[i] = 8'($urandom);
            if ($urandom_range(3) == 0) plan_ctrl[DIS_LSB + i] = 1'b1;
            if ($urandom_range(1) == 1) plan_ctrl[CMP_LSB + i] = 1'b1;
        end

        // directed: setup mode corners
        add_access(CMD_READ,  16'h0000,    8'h00, 1'b0);
        add_access(CMD_READ,  16'hFFFF,    8'hFF, 1'b0);
        add_access(CMD_WRITE, 16'h7FFF,    8'hFF, 1'b0);
        add_access(CMD_WRITE, 16'h800D,    8'hFF, 1'b0);
        add_access(CMD_WRITE, C_CTRL_ADDR, 8'hFF, 1'b0);
        add_access(CMD_WRITE, C_CTRL_ADDR, 8'h01, 1'b0);
        add_access(CMD_WRITE, 16'h8001,    8'hFF, 1'b0);
        add_access(CMD_WRITE, 16'h8002,    8'hFF, 1'b0);
        add_access(CMD_WRITE, 16'h8003,    8'h00, 1'b0);
        add_access(CMD_WRITE, 16'h8004,    8'hFF, 1'b0);
        add_access(CMD_WRITE, C_SLOT_LAST, 8'h00, 1'b0);

        // random setup traffic
        for (int i = 0; i < 40; i++) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                add_access(CMD_WRITE, 16'($urandom_range(C_SLOT_LAST, C_SLOT_FIRST)),
                           8'($urandom), 1'b0);
            end else if (sel < 80) begin
                add_access(CMD_WRITE, C_CTRL_ADDR, 8'($urandom) | 8'h01, 1'b0);
            end else if (sel < 90) begin
                add_access(CMD_READ, 16'($urandom), 8'($urandom), 1'b0);
            end else if (sel < 95) begin
                add_access(CMD_WRITE, 16'($urandom) & 16'h7FFF, 8'($urandom), 1'b0);
            end else begin
                add_access(CMD_WRITE, 16'($urandom_range(16'hFFFF, 16'h800D)),
                           8'($urandom), 1'b0);
            end
        end

        // final slot contents in a rotated order, then the control byte
        start = $urandom_range(11);
        for (int j = 0; j < 12; j++) begin
            k = (start + j) % 12;
            case (t_field'(k % 4))
                F_ADDR_HI: fld = plan_addr[k / 4][15:8];
                F_ADDR_LO: fld = plan_addr[k / 4][7:0];
                F_CMP:     fld = plan_cmp[k / 4];
                default:   fld = plan_rep[k / 4];
            endcase
            add_access(CMD_WRITE, C_SLOT_FIRST + 16'(k), fld, 1'b0);
        end
        add_access(CMD_WRITE, C_CTRL_ADDR, plan_ctrl, 1'b0);

        // leave setup mode once everything before it has drained
        add_access(CMD_WRITE, C_CTRL_ADDR, 8'($urandom) & 8'hFE, 1'b1);

        // directed: patching corners
        add_access(CMD_WRITE, C_CTRL_ADDR,  8'h01, 1'b0);
        add_access(CMD_WRITE, C_SLOT_FIRST, 8'hAA, 1'b0);
        add_access(CMD_READ,  16'h7FFF,     plan_cmp[0], 1'b0);
        add_access(CMD_READ,  C_CTRL_ADDR,  8'($urandom), 1'b0);
        for (int i = 0; i < N_SLOTS; i++) begin
            add_access(CMD_READ, plan_addr[i], plan_cmp[i], 1'b0);
            add_access(CMD_READ, plan_addr[i], ~plan_cmp[i], 1'b0);
        end

        // random patching traffic, mostly aimed at the loaded slots
        n_counted = 0;
        while (n_counted < 700) begin
            sel  = $urandom_range(99);
            k    = $urandom_range(N_SLOTS - 1);
            hold = (n_counted % 200 == 199);
            if (sel < 60) begin
                add_access(CMD_READ, plan_addr[k],
                           $urandom_range(1) ? plan_cmp[k] : 8'($urandom), hold);
                n_counted++;
            end else if (sel < 75) begin
                add_access(CMD_READ, 16'(16'h8000 | $urandom), 8'($urandom), hold);
                n_counted++;
            end else if (sel < 85) begin
                add_access(CMD_READ, plan_addr[k] & 16'h7FFF, 8'($urandom), hold);
                n_counted++;
            end else if (sel < 90) begin
                add_access(CMD_READ, $urandom_range(1) ? 16'hFFFF : C_CTRL_ADDR,
                           $urandom_range(1) ? 8'hFF : 8'h00, hold);
                n_counted++;
            end else begin
                add_access(CMD_WRITE, 16'($urandom), 8'($urandom), hold);
            end
        end

        @(posedge rst_n);
        while (pending_access_q.size() != 0 || in_if.valid) @(posedge clk);
        while (predicted_rsp_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("bus transfers: %0d reads, %0d writes, %0d results checked",
                 n_reads, n_writes, n_results);
        $display("patched reads per slot %0d/%0d/%0d, control %02h, mismatches %0d",
                 slot_hits[1], slot_hits[2], slot_hits[3], ctrl_q, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
